// ===== sv/sensor_power_cycle_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// sensor power cycle scheduler assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SENSOR_POWER_CYCLE_SCHEDULER_DEFINES_SVH
`define SENSOR_POWER_CYCLE_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define SPCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spcs_pkg.sv =====
// ----------------------------------------------------------------------------
// spcs_pkg
// types and codes shared by the sensor power cycle scheduler modules
// ----------------------------------------------------------------------------
package spcs_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned PPM_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEAVE_OFF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 3'd3;

	// register reset values
	localparam logic [TIME_W-1:0] LEAVE_OFF_RST = 32'd10000;
	localparam logic [TIME_W-1:0] CYCLE_RST     = 32'd3600000;
	localparam logic [TIME_W-1:0] READ_RST      = 32'd2000;
	localparam logic [TIME_W-1:0] WARMUP_RST    = 32'd10000;

	// operations
	localparam logic OP_START  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// status levels
	localparam logic [1:0] LVL_OK   = 2'd0;
	localparam logic [1:0] LVL_WARN = 2'd1;
	localparam logic [1:0] LVL_ERR  = 2'd2;

	// status codes
	localparam logic [2:0] C_OK           = 3'd0;
	localparam logic [2:0] C_INIT_FAIL    = 3'd1;
	localparam logic [2:0] C_INITIALIZING = 3'd2;
	localparam logic [2:0] C_POWER_OFF    = 3'd3;
	localparam logic [2:0] C_READ_FAIL    = 3'd4;

	typedef struct packed {
		logic              operation;
		logic [TIME_W-1:0] now_ms;
		logic              init_ok;
		logic              measure_ok;
		logic [PPM_W-1:0]  measured_ppm;
	} spcs_in_t;

	typedef struct packed {
		logic [1:0]       health_level;
		logic [2:0]       health_code;
		logic             power_on_cmd;
		logic             power_off_cmd;
		logic             measure_attempted;
		logic             reading_valid;
		logic [PPM_W-1:0] co2_ppm;
	} spcs_out_t;

	typedef struct packed {
		logic [TIME_W-1:0] leave_off_ms;
		logic [TIME_W-1:0] cycle_interval_ms;
		logic [TIME_W-1:0] read_interval_ms;
		logic [TIME_W-1:0] warmup_ms;
	} spcs_cfg_t;

	typedef struct packed {
		logic              powered;
		logic              warming;
		logic [1:0]        level;
		logic [2:0]        code;
		logic [TIME_W-1:0] last_read_time;
		logic [TIME_W-1:0] last_cycle_time;
		logic [TIME_W-1:0] warm_start_time;
	} spcs_state_t;

endpackage

// ===== sv/sensor_power_cycle_scheduler.sv =====
// ----------------------------------------------------------------------------
// sensor_power_cycle_scheduler
// power, warm-up and read scheduling for a gas sensor, one result per event
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data  (spcs_in_t)
// out     | output    | out_valid / out_ready | out_data (spcs_out_t)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one transaction per cycle while the output is not stalled; an accepted transaction
// passes the input register, then the result register (updated together with the state)
// reset clears the sensor state and loads register defaults, no warm-up pass
// a stalled output holds the result and backs up into the input register
// ----------------------------------------------------------------------------
module sensor_power_cycle_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  spcs_pkg::spcs_in_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output spcs_pkg::spcs_out_t            out_data,
	input  logic                           cfg_we,
	input  logic [spcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spcs_pkg::TIME_W-1:0]    cfg_data
);
	import spcs_pkg::*;
	`include "sensor_power_cycle_scheduler_defines.svh"

	spcs_cfg_t   cfg;
	spcs_state_t state_q;
	spcs_state_t state_next;
	spcs_in_t    item_s1;
	logic        valid_s1;
	spcs_out_t   res;
	spcs_out_t   res_s2;
	logic        valid_s2;
	logic        advance;

	spcs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	spcs_step u_step (
		.st     (state_q),
		.cfg    (cfg),
		.item   (item_s1),
		.st_next(state_next),
		.res    (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// a processed transaction always lands in the result register
	`SPCS_ASSERT_NXT(a_adv_loads, advance, valid_s2, "result register not loaded")
	// an empty input register never blocks the input channel
	`SPCS_ASSERT_IMP(a_s1_free, !valid_s1, in_ready, "input stalled while empty")
	// a held input transaction keeps its payload until processed
	`SPCS_ASSERT_NXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(item_s1),
		"input register lost its transaction")
	// a published reading comes from a measurement and never with a power-off
	`SPCS_ASSERT_IMP(a_read_clean, valid_s2 && res_s2.reading_valid,
		res_s2.measure_attempted && !res_s2.power_off_cmd,
		"reading published with a power-off")

endmodule

// ===== sv/spcs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// spcs_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module spcs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spcs_pkg::TIME_W-1:0]    cfg_data,
	output spcs_pkg::spcs_cfg_t            cfg
);
	import spcs_pkg::*;

	spcs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leave_off_ms      <= LEAVE_OFF_RST;
			cfg_q.cycle_interval_ms <= CYCLE_RST;
			cfg_q.read_interval_ms  <= READ_RST;
			cfg_q.warmup_ms         <= WARMUP_RST;
		end else if (cfg_we) begin
			// indexes past the last register are dropped
			unique case (cfg_index)
				REG_LEAVE_OFF: cfg_q.leave_off_ms      <= cfg_data;
				REG_CYCLE:     cfg_q.cycle_interval_ms <= cfg_data;
				REG_READ:      cfg_q.read_interval_ms  <= cfg_data;
				REG_WARMUP:    cfg_q.warmup_ms         <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/spcs_step.sv =====
// ----------------------------------------------------------------------------
// spcs_step
// next-state and result logic for one transaction of the scheduler
// ----------------------------------------------------------------------------
module spcs_step (
	input  spcs_pkg::spcs_state_t st,
	input  spcs_pkg::spcs_cfg_t   cfg,
	input  spcs_pkg::spcs_in_t    item,
	output spcs_pkg::spcs_state_t st_next,
	output spcs_pkg::spcs_out_t   res
);
	import spcs_pkg::*;

	function automatic spcs_state_t start_sensor(spcs_state_t s, logic ok,
			logic [TIME_W-1:0] now);
		spcs_state_t r;
		r = s;
		r.powered = 1'b1;
		if (!ok) begin
			r.level = LVL_ERR;
			r.code  = C_INIT_FAIL;
		end else begin
			r.level           = LVL_WARN;
			r.code            = C_INITIALIZING;
			r.warm_start_time = now;
			r.warming         = 1'b1;
		end
		return r;
	endfunction

	spcs_state_t       ns;
	logic              done;
	logic              on_cmd;
	logic              off_cmd;
	logic              meas;
	logic              valid;
	logic [TIME_W-1:0] now;

	assign now = item.now_ms;

	always_comb begin
		ns      = st;
		done    = 1'b0;
		on_cmd  = 1'b0;
		off_cmd = 1'b0;
		meas    = 1'b0;
		valid   = 1'b0;
		if (item.operation == OP_START) begin
			ns     = start_sensor(st, item.init_ok, now);
			on_cmd = 1'b1;
		end else if (st.last_cycle_time > now || st.last_read_time > now) begin
			// clock rolled over: drop power and restart the timers
			ns.last_read_time  = '0;
			ns.powered         = 1'b0;
			ns.last_cycle_time = now;
			ns.level           = LVL_WARN;
			ns.code            = C_POWER_OFF;
			off_cmd            = 1'b1;
		end else begin
			if (!st.powered) begin
				if (TIME_W'(now - st.last_cycle_time) > cfg.leave_off_ms) begin
					ns     = start_sensor(st, item.init_ok, now);
					on_cmd = 1'b1;
				end else begin
					ns.level = LVL_WARN;
					ns.code  = C_POWER_OFF;
					done     = 1'b1;
				end
			end
			if (!done && ns.warming) begin
				if (TIME_W'(now - ns.warm_start_time) < cfg.warmup_ms) begin
					done = 1'b1;
				end else begin
					ns.warming = 1'b0;
					ns.level   = LVL_OK;
					ns.code    = C_OK;
				end
			end
			if (!done && TIME_W'(now - ns.last_cycle_time) > cfg.cycle_interval_ms) begin
				ns.powered         = 1'b0;
				ns.last_cycle_time = now;
				ns.level           = LVL_WARN;
				ns.code            = C_POWER_OFF;
				off_cmd            = 1'b1;
				done               = 1'b1;
			end
			if (!done && TIME_W'(now - ns.last_read_time) > cfg.read_interval_ms) begin
				meas = 1'b1;
				if (item.measure_ok) begin
					if (ns.level == LVL_OK) begin
						valid = 1'b1;
					end else begin
						ns     = start_sensor(ns, item.init_ok, now);
						on_cmd = 1'b1;
					end
				end else begin
					if (ns.level != LVL_ERR) begin
						ns.level = LVL_ERR;
						ns.code  = C_READ_FAIL;
					end
					ns     = start_sensor(ns, item.init_ok, now);
					on_cmd = 1'b1;
				end
				ns.last_read_time = now;
			end
		end
	end

	assign st_next = ns;

	always_comb begin
		res.health_level      = ns.level;
		res.health_code       = ns.code;
		res.power_on_cmd      = on_cmd;
		res.power_off_cmd     = off_cmd;
		res.measure_attempted = meas;
		res.reading_valid     = valid;
		res.co2_ppm           = valid ? item.measured_ppm : '0;
	end

endmodule
